// ===== rtl/ipc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared widths, codes, reset values and types of the incremental PI heater
// controller with PWM compare output.
// ----------------------------------------------------------------------------
package ipc_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int TEMP_W   = 12;
	localparam int GAIN_W   = 16;
	localparam int CMP_W    = 15;
	localparam int CLAMP_W  = 2;
	localparam int ERR_W    = TEMP_W + 1;
	localparam int DELTA_W  = ERR_W + 1;
	localparam int SUM_W    = 31;
	localparam int SHIFT    = 8;
	localparam int UFULL_W  = SUM_W - SHIFT;
	localparam int U_W      = 16;
	localparam int NEXT_W   = 22;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOK_UPPER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOK_LOWER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARM_UPPER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARM_LOWER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_COMPARE = 3'd6;

	// Register reset values
	localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 16'd256;
	localparam logic [GAIN_W-1:0] RST_INTEG_GAIN    = 16'd256;
	localparam logic [CMP_W-1:0]  RST_COOK_UPPER    = 15'd32767;
	localparam logic [CMP_W-1:0]  RST_COOK_LOWER    = 15'd0;
	localparam logic [CMP_W-1:0]  RST_WARM_UPPER    = 15'd32767;
	localparam logic [CMP_W-1:0]  RST_WARM_LOWER    = 15'd0;
	localparam logic [CMP_W-1:0]  RST_START_COMPARE = 15'd0;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_COOK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WARM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd2;

	// Clamp status codes
	localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
	localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
	localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

	// PWM scale applied to the controller output
	localparam logic signed [NEXT_W-1:0] PWM_SCALE = 22'sd20;

	// Saturation bounds of the controller output
	localparam logic signed [UFULL_W-1:0] U_MAX = 23'sd32767;
	localparam logic signed [UFULL_W-1:0] U_MIN = -23'sd32768;

	// Current register contents
	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [CMP_W-1:0]  cook_upper;
		logic [CMP_W-1:0]  cook_lower;
		logic [CMP_W-1:0]  warm_upper;
		logic [CMP_W-1:0]  warm_lower;
		logic              load;
		logic [CMP_W-1:0]  start_compare;
	} cfg_t;

	// Outcome of one controller step
	typedef struct packed {
		logic                     update;
		logic signed [ERR_W-1:0]  error;
		logic [CMP_W-1:0]         compare;
		logic [CLAMP_W-1:0]       clamp;
	} step_t;

endpackage

// ===== rtl/ipc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_if
// Valid/ready channels of the controller: sample words in, result words out
// and register writes.
// ----------------------------------------------------------------------------
interface ipc_sample_if;
	logic                             valid;
	logic                             ready;
	logic [ipc_pkg::MODE_W-1:0]       mode;
	logic [ipc_pkg::TEMP_W-1:0]       target_temp;
	logic [ipc_pkg::TEMP_W-1:0]       measured_temp;

	modport source (output valid, mode, target_temp, measured_temp, input ready);
	modport sink   (input valid, mode, target_temp, measured_temp, output ready);
endinterface

interface ipc_result_if;
	logic                             valid;
	logic                             ready;
	logic [ipc_pkg::CMP_W-1:0]        compare_value;
	logic [ipc_pkg::CLAMP_W-1:0]      clamp_state;

	modport source (output valid, compare_value, clamp_state, input ready);
	modport sink   (input valid, compare_value, clamp_state, output ready);
endinterface

interface ipc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ipc_pkg::CFG_IDX_W-1:0]    index;
	logic [ipc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/incremental_pi_pwm_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_pwm_compare
// Incremental PI heater controller that drives a PWM compare value.
// ----------------------------------------------------------------------------
// Each sample word passes through an input register and then combinational
// logic (error, two gain multiplies, saturation, PWM scale and clamp) into
// the result register, and a new sample can be taken every cycle while the
// result side keeps up. The
// controller state (previous error and compare value) is updated in the same
// cycle as the result is registered, which keeps the one-word-per-cycle rate.
// The result register lets the next sample enter while a result waits.
// Register writes are taken every cycle; they must only be made while no
// sample is in flight. Writing the start compare register also loads it into
// the compare value.
// ----------------------------------------------------------------------------
module incremental_pi_pwm_compare (
	input  logic           clk,
	input  logic           arst_n,
	ipc_sample_if.sink     sample,
	ipc_result_if.source   result,
	ipc_cfg_if.sink        cfg
);

	ipc_pkg::cfg_t                           regs;
	ipc_pkg::step_t                          step;

	logic                                    valid_s1;
	logic [ipc_pkg::MODE_W-1:0]              mode_s1;
	logic [ipc_pkg::TEMP_W-1:0]              target_s1;
	logic [ipc_pkg::TEMP_W-1:0]              measured_s1;

	logic                                    out_valid_q;
	logic [ipc_pkg::CMP_W-1:0]               out_compare_q;
	logic [ipc_pkg::CLAMP_W-1:0]             out_clamp_q;

	logic signed [ipc_pkg::ERR_W-1:0]        prev_error_q;
	logic [ipc_pkg::CMP_W-1:0]               compare_q;

	logic                                    advance;
	logic                                    take;

	ipc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ipc_step u_step (
		.regs          (regs),
		.mode          (mode_s1),
		.target_temp   (target_s1),
		.measured_temp (measured_s1),
		.prev_error    (prev_error_q),
		.compare       (compare_q),
		.step          (step)
	);

	// Move the held word on when the result register is free or draining
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1     <= sample.mode;
			target_s1   <= sample.target_temp;
			measured_s1 <= sample.measured_temp;
		end
	end

	// Controller state; a start compare write loads the compare value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			compare_q    <= ipc_pkg::RST_START_COMPARE;
		end else if (regs.load) begin
			compare_q <= regs.start_compare;
		end else if (advance && step.update) begin
			prev_error_q <= step.error;
			compare_q    <= step.compare;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_compare_q <= step.compare;
			out_clamp_q   <= step.clamp;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.compare_value = out_compare_q;
	assign result.clamp_state   = out_clamp_q;

endmodule

// ===== rtl/ipc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_cfg_regs
// Register file of gains, clamp limits and start compare value. A write to
// the start compare register also raises a one-cycle load strobe.
// ----------------------------------------------------------------------------
module ipc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	ipc_cfg_if.sink           cfg,
	output ipc_pkg::cfg_t     regs
);

	logic                           wr;
	logic [ipc_pkg::GAIN_W-1:0]     prop_gain_q;
	logic [ipc_pkg::GAIN_W-1:0]     integ_gain_q;
	logic [ipc_pkg::CMP_W-1:0]      cook_upper_q;
	logic [ipc_pkg::CMP_W-1:0]      cook_lower_q;
	logic [ipc_pkg::CMP_W-1:0]      warm_upper_q;
	logic [ipc_pkg::CMP_W-1:0]      warm_lower_q;
	logic [ipc_pkg::CMP_W-1:0]      start_compare_q;
	logic                           load_q;

	// Always take a write word
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Decode the index; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= ipc_pkg::RST_PROP_GAIN;
			integ_gain_q    <= ipc_pkg::RST_INTEG_GAIN;
			cook_upper_q    <= ipc_pkg::RST_COOK_UPPER;
			cook_lower_q    <= ipc_pkg::RST_COOK_LOWER;
			warm_upper_q    <= ipc_pkg::RST_WARM_UPPER;
			warm_lower_q    <= ipc_pkg::RST_WARM_LOWER;
			start_compare_q <= ipc_pkg::RST_START_COMPARE;
			load_q          <= 1'b0;
		end else begin
			load_q <= 1'b0;
			if (wr) begin
				case (cfg.index)
					ipc_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg.data;
					ipc_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg.data;
					ipc_pkg::REG_COOK_UPPER: cook_upper_q <= cfg.data[ipc_pkg::CMP_W-1:0];
					ipc_pkg::REG_COOK_LOWER: cook_lower_q <= cfg.data[ipc_pkg::CMP_W-1:0];
					ipc_pkg::REG_WARM_UPPER: warm_upper_q <= cfg.data[ipc_pkg::CMP_W-1:0];
					ipc_pkg::REG_WARM_LOWER: warm_lower_q <= cfg.data[ipc_pkg::CMP_W-1:0];
					ipc_pkg::REG_START_COMPARE: begin
						start_compare_q <= cfg.data[ipc_pkg::CMP_W-1:0];
						load_q          <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign regs.prop_gain     = prop_gain_q;
	assign regs.integ_gain    = integ_gain_q;
	assign regs.cook_upper    = cook_upper_q;
	assign regs.cook_lower    = cook_lower_q;
	assign regs.warm_upper    = warm_upper_q;
	assign regs.warm_lower    = warm_lower_q;
	assign regs.load          = load_q;
	assign regs.start_compare = start_compare_q;

endmodule

// ===== rtl/ipc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_step
// One controller step: error and delta, the two gain products, truncating
// shift and saturation, the PWM scale, and the clamp to the mode's limits.
// ----------------------------------------------------------------------------
module ipc_step (
	input  ipc_pkg::cfg_t                        regs,
	input  logic [ipc_pkg::MODE_W-1:0]           mode,
	input  logic [ipc_pkg::TEMP_W-1:0]           target_temp,
	input  logic [ipc_pkg::TEMP_W-1:0]           measured_temp,
	input  logic signed [ipc_pkg::ERR_W-1:0]     prev_error,
	input  logic [ipc_pkg::CMP_W-1:0]            compare,
	output ipc_pkg::step_t                       step
);

	logic                                    active;
	logic [ipc_pkg::CMP_W-1:0]               upper;
	logic [ipc_pkg::CMP_W-1:0]               lower;
	logic signed [ipc_pkg::ERR_W-1:0]        error;
	logic signed [ipc_pkg::DELTA_W-1:0]      delta;
	logic signed [ipc_pkg::SUM_W-1:0]        prod_p;
	logic signed [ipc_pkg::SUM_W-1:0]        prod_i;
	logic signed [ipc_pkg::SUM_W-1:0]        sum;
	logic signed [ipc_pkg::SUM_W-1:0]        sum_adj;
	logic signed [ipc_pkg::UFULL_W-1:0]      u_full;
	logic signed [ipc_pkg::U_W-1:0]          u_sat;
	logic signed [ipc_pkg::NEXT_W-1:0]       scaled;
	logic signed [ipc_pkg::NEXT_W-1:0]       next;
	logic signed [ipc_pkg::NEXT_W-1:0]       upper_x;
	logic signed [ipc_pkg::NEXT_W-1:0]       lower_x;

	// Cook and warm run the loop; idle and the unused code hold
	assign active = (mode == ipc_pkg::MODE_COOK) || (mode == ipc_pkg::MODE_WARM);
	assign upper  = (mode == ipc_pkg::MODE_COOK) ? regs.cook_upper : regs.warm_upper;
	assign lower  = (mode == ipc_pkg::MODE_COOK) ? regs.cook_lower : regs.warm_lower;

	// Error and its change since the last active step
	assign error = signed'({1'b0, target_temp}) - signed'({1'b0, measured_temp});
	assign delta = ipc_pkg::DELTA_W'(error) - ipc_pkg::DELTA_W'(prev_error);

	// Gain products, Q8.8 times integer
	assign prod_p = signed'({{(ipc_pkg::SUM_W-ipc_pkg::GAIN_W){1'b0}}, regs.prop_gain})
		* ipc_pkg::SUM_W'(delta);
	assign prod_i = signed'({{(ipc_pkg::SUM_W-ipc_pkg::GAIN_W){1'b0}}, regs.integ_gain})
		* ipc_pkg::SUM_W'(error);
	assign sum    = prod_p + prod_i;

	// Drop the fraction, rounding toward zero
	assign sum_adj = sum + (sum[ipc_pkg::SUM_W-1] ?
		ipc_pkg::SUM_W'((1 << ipc_pkg::SHIFT) - 1) : '0);
	assign u_full  = ipc_pkg::UFULL_W'(sum_adj >>> ipc_pkg::SHIFT);

	// Saturate to sixteen bits
	always_comb begin
		if (u_full > ipc_pkg::U_MAX) begin
			u_sat = ipc_pkg::U_W'(ipc_pkg::U_MAX);
		end else if (u_full < ipc_pkg::U_MIN) begin
			u_sat = ipc_pkg::U_W'(ipc_pkg::U_MIN);
		end else begin
			u_sat = ipc_pkg::U_W'(u_full);
		end
	end

	// Scale and subtract from the compare value
	assign scaled  = ipc_pkg::NEXT_W'(u_sat) * ipc_pkg::PWM_SCALE;
	assign next    = signed'({{(ipc_pkg::NEXT_W-ipc_pkg::CMP_W){1'b0}}, compare}) - scaled;
	assign upper_x = signed'({{(ipc_pkg::NEXT_W-ipc_pkg::CMP_W){1'b0}}, upper});
	assign lower_x = signed'({{(ipc_pkg::NEXT_W-ipc_pkg::CMP_W){1'b0}}, lower});

	// Clamp: the upper limit is tested first
	always_comb begin
		step.update = active;
		step.error  = error;
		if (!active) begin
			step.compare = compare;
			step.clamp   = ipc_pkg::CLAMP_NONE;
		end else if (next > upper_x) begin
			step.compare = upper;
			step.clamp   = ipc_pkg::CLAMP_HIGH;
		end else if (next < lower_x) begin
			step.compare = lower;
			step.clamp   = ipc_pkg::CLAMP_LOW;
		end else begin
			step.compare = next[ipc_pkg::CMP_W-1:0];
			step.clamp   = ipc_pkg::CLAMP_NONE;
		end
	end

endmodule
